### hdl/delta_position_log_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the position log encoder
// Shared concurrent assertion forms used by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef DELTA_POSITION_LOG_ENCODER_UNIT_DEFINES_SVH
`define DELTA_POSITION_LOG_ENCODER_UNIT_DEFINES_SVH

// Checked outside reset only.
`define DPLOG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define DPLOG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/dplog_pkg.sv
// ----------------------------------------------------------------------------
// dplog_pkg
// Types, codes and constants shared by the position log encoder modules.
// ----------------------------------------------------------------------------
package dplog_pkg;

   localparam int NOW_W        = 31;
   localparam int VALUE_W      = 32;
   localparam int WORD_W       = 32;
   localparam int PERIOD_W     = 16;
   localparam int SYNC_CNT_W   = 8;
   localparam int LEFT_W       = 8;
   localparam int DELTA_W      = 16;
   // due time spans -(256 * 65535) .. 2^31 - 1 + 256 * 65535
   localparam int DUE_W        = 34;
   localparam int PROD_W       = PERIOD_W + SYNC_CNT_W + 1;

   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam int DEFAULT_FIFO_DEPTH = 128;
   localparam int CMDQ_DEPTH         = 4;

   localparam int RESET_PERIOD       = 200;
   localparam int RESET_SYNC_ENTRIES = 50;

   localparam logic [PERIOD_W-1:0]   RESET_PERIOD_VAL  = PERIOD_W'(RESET_PERIOD);
   localparam logic [SYNC_CNT_W-1:0] RESET_SYNC_VAL    = SYNC_CNT_W'(RESET_SYNC_ENTRIES);
   localparam logic signed [DUE_W-1:0] RESET_SYNC_TIME =
      DUE_W'(-(RESET_SYNC_ENTRIES + 1) * RESET_PERIOD);

   localparam logic [WORD_W-1:0] SYNC_MARKER = 32'h8000_0000;
   localparam logic [WORD_W-1:0] VALUE_MASK  = 32'h7fff_ffff;
   localparam logic [LEFT_W-1:0] LEFT_MAX    = 8'hff;

   // request operation codes
   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_PERIOD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_ENTRIES = 2'd2;

   typedef enum logic [1:0] {
      CMD_REL,
      CMD_SYNC,
      CMD_CLEAR,
      CMD_READ
   } cmd_kind_type;

   typedef enum logic [1:0] {
      STEP_MARKER,
      STEP_STAMP,
      STEP_VALUE_A,
      STEP_VALUE_B
   } sync_step_type;

   // word_a carries the packed delta word for a relative command
   typedef struct packed {
      cmd_kind_type       kind;
      logic [NOW_W-1:0]   stamp;
      logic [VALUE_W-1:0] word_a;
      logic [VALUE_W-1:0] word_b;
   } cmd_type;

endpackage

### hdl/dplog_req_if.sv
// ----------------------------------------------------------------------------
// dplog_req_if
// Request channel: operation code, sample time and the two logged values.
// ----------------------------------------------------------------------------
interface dplog_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic [30:0]        now_ms;
   logic signed [31:0] value_a;
   logic signed [31:0] value_b;

   modport source (output valid, output op, output now_ms, output value_a,
                   output value_b, input ready);
   modport sink   (input valid, input op, input now_ms, input value_a,
                   input value_b, output ready);
endinterface

### hdl/dplog_rsp_if.sv
// ----------------------------------------------------------------------------
// dplog_rsp_if
// Response channel: one popped log word with fill and overflow status.
// ----------------------------------------------------------------------------
interface dplog_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] entry_word;
   logic        entry_valid;
   logic [7:0]  entries_left;
   logic        overflowed;

   modport source (output valid, output entry_word, output entry_valid,
                   output entries_left, output overflowed, input ready);
   modport sink   (input valid, input entry_word, input entry_valid,
                   input entries_left, input overflowed, output ready);
endinterface

### hdl/dplog_front.sv
// ----------------------------------------------------------------------------
// dplog_front
// Accepts requests, runs the due-time test and resync decision, holds the
// configuration registers and issues log commands to the command queue.
// ----------------------------------------------------------------------------
module dplog_front import dplog_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dplog_req_if.sink             req_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  cmdq_full,
   output logic                  cmdq_push,
   output cmd_type               cmdq_cmd
);

   logic                    enable_ff, enable_in;
   logic [PERIOD_W-1:0]     period_ff, period_in;
   logic [SYNC_CNT_W-1:0]   ebs_ff, ebs_in;
   logic [SYNC_CNT_W-1:0]   since_ff, since_in;
   logic signed [DUE_W-1:0] sync_ff, sync_in;
   logic signed [DUE_W-1:0] due_ff, due_in;
   logic [VALUE_W-1:0]      base_a_ff, base_a_in;
   logic [VALUE_W-1:0]      base_b_ff, base_b_in;
   logic [1:0]              refresh_ff, refresh_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;

   logic                    accept;
   logic [SYNC_CNT_W:0]     since_inc;
   logic [SYNC_CNT_W:0]     ebs_inc;
   logic [PROD_W-1:0]       restart_span;
   logic signed [DUE_W-1:0] now_ext;
   logic signed [DUE_W-1:0] period_ext;
   logic                    due_hit;
   logic                    is_rel;
   logic [DELTA_W-1:0]      delta_a;
   logic [DELTA_W-1:0]      delta_b;

   // hold off requests while the due time is rebuilt after a period write
   assign req_ch.ready = !cmdq_full && (refresh_ff == 2'b00);
   assign accept       = req_ch.valid && req_ch.ready;

   assign since_inc    = {1'b0, since_ff} + 1'b1;
   assign ebs_inc      = {1'b0, ebs_ff} + 1'b1;
   assign restart_span = {{(PROD_W-SYNC_CNT_W-1){1'b0}}, ebs_inc}
                       * {{(PROD_W-PERIOD_W){1'b0}}, period_ff};
   assign prod_in      = {{(PROD_W-SYNC_CNT_W-1){1'b0}}, since_inc}
                       * {{(PROD_W-PERIOD_W){1'b0}}, period_ff};
   assign now_ext      = $signed({{(DUE_W-NOW_W){1'b0}}, req_ch.now_ms});
   assign period_ext   = $signed({{(DUE_W-PERIOD_W){1'b0}}, period_ff});
   assign due_hit      = now_ext >= due_ff;
   assign is_rel       = since_inc <= {1'b0, ebs_ff};
   assign delta_a      = req_ch.value_a[DELTA_W-1:0] - base_a_ff[DELTA_W-1:0];
   assign delta_b      = req_ch.value_b[DELTA_W-1:0] - base_b_ff[DELTA_W-1:0];

   always_comb begin
      enable_in  = enable_ff;
      period_in  = period_ff;
      ebs_in     = ebs_ff;
      since_in   = since_ff;
      sync_in    = sync_ff;
      due_in     = due_ff;
      base_a_in  = base_a_ff;
      base_b_in  = base_b_ff;
      refresh_in = {refresh_ff[0], 1'b0};
      cmdq_push  = 1'b0;
      cmdq_cmd.kind   = CMD_READ;
      cmdq_cmd.stamp  = req_ch.now_ms;
      cmdq_cmd.word_a = req_ch.value_a;
      cmdq_cmd.word_b = req_ch.value_b;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LOG_ENABLE: begin
               enable_in = csr_wdata[0];
            end
            CSR_LOG_PERIOD: begin
               period_in     = csr_wdata[PERIOD_W-1:0];
               refresh_in[0] = 1'b1;
            end
            CSR_SYNC_ENTRIES: begin
               ebs_in = csr_wdata[SYNC_CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end

      // rebuild due = sync + (since + 1) * period with the new period
      if (refresh_ff[1]) begin
         due_in = sync_ff + $signed({{(DUE_W-PROD_W){1'b0}}, prod_ff});
      end

      if (accept) begin
         unique case (req_ch.op)
            OP_SAMPLE: begin
               if (enable_ff && due_hit) begin
                  cmdq_push = 1'b1;
                  if (is_rel) begin
                     cmdq_cmd.kind   = CMD_REL;
                     cmdq_cmd.word_a = {delta_b, delta_a};
                     since_in        = since_inc[SYNC_CNT_W-1:0];
                     due_in          = due_ff + period_ext;
                  end else begin
                     cmdq_cmd.kind = CMD_SYNC;
                     since_in      = '0;
                     sync_in       = now_ext;
                     due_in        = now_ext + period_ext;
                     base_a_in     = req_ch.value_a;
                     base_b_in     = req_ch.value_b;
                  end
               end
            end
            OP_READ: begin
               cmdq_push     = 1'b1;
               cmdq_cmd.kind = CMD_READ;
            end
            OP_RESTART: begin
               cmdq_push     = 1'b1;
               cmdq_cmd.kind = CMD_CLEAR;
               since_in      = ebs_ff;
               sync_in       = -$signed({{(DUE_W-PROD_W){1'b0}}, restart_span});
               // sync + (ebs + 1) * period cancels to zero
               due_in        = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         period_ff  <= RESET_PERIOD_VAL;
         ebs_ff     <= RESET_SYNC_VAL;
         since_ff   <= RESET_SYNC_VAL;
         sync_ff    <= RESET_SYNC_TIME;
         due_ff     <= '0;
         base_a_ff  <= '0;
         base_b_ff  <= '0;
         refresh_ff <= 2'b00;
      end else begin
         enable_ff  <= enable_in;
         period_ff  <= period_in;
         ebs_ff     <= ebs_in;
         since_ff   <= since_in;
         sync_ff    <= sync_in;
         due_ff     <= due_in;
         base_a_ff  <= base_a_in;
         base_b_ff  <= base_b_in;
         refresh_ff <= refresh_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

### hdl/dplog_queue.sv
// ----------------------------------------------------------------------------
// dplog_queue
// Short command queue between the request front end and the log back end.
// ----------------------------------------------------------------------------
module dplog_queue import dplog_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd,
   input  logic    pop
);

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            slot_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = count_ff == CNT_W'(CMDQ_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/dplog_back.sv
// ----------------------------------------------------------------------------
// dplog_back
// Executes log commands against the word FIFO memory and returns read
// results through a registered response stage.
// ----------------------------------------------------------------------------
module dplog_back import dplog_pkg::*; #(
   parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   dplog_rsp_if.source rsp_ch
);

   `include "delta_position_log_encoder_unit_defines.svh"

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [WORD_W-1:0] fifo_mem_ff [FIFO_DEPTH];
   logic [WORD_W-1:0] mem_q_ff;

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   sync_step_type     step_ff, step_in;

   logic              pend_ff, pend_in;
   logic              pend_hit_ff, pend_hit_in;
   logic [LEFT_W-1:0] pend_left_ff, pend_left_in;
   logic              pend_ovf_ff, pend_ovf_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_hit_ff;
   logic [LEFT_W-1:0] rsp_left_ff;
   logic              rsp_ovf_ff;

   logic              wr_req;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic              rd_issue;
   logic              rd_slot_free;
   logic [CNT_W-1:0]  count_dec;

   assign rd_slot_free = !pend_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign count_dec    = count_ff - 1'b1;
   assign wr_en        = wr_req && (count_ff < CNT_W'(FIFO_DEPTH));

   always_comb begin
      wr_req   = 1'b0;
      wr_data  = cmd.word_a;
      rd_issue = 1'b0;
      cmd_pop  = 1'b0;
      step_in  = step_ff;
      if (cmd_valid) begin
         unique case (cmd.kind)
            CMD_REL: begin
               wr_req  = 1'b1;
               cmd_pop = 1'b1;
            end
            CMD_SYNC: begin
               wr_req = 1'b1;
               unique case (step_ff)
                  STEP_MARKER: begin
                     wr_data = SYNC_MARKER
                             | {{(WORD_W-3){1'b0}}, cmd.word_b[VALUE_W-1],
                                cmd.word_a[VALUE_W-1], 1'b0};
                     step_in = STEP_STAMP;
                  end
                  STEP_STAMP: begin
                     wr_data = {1'b0, cmd.stamp};
                     step_in = STEP_VALUE_A;
                  end
                  STEP_VALUE_A: begin
                     wr_data = cmd.word_a & VALUE_MASK;
                     step_in = STEP_VALUE_B;
                  end
                  STEP_VALUE_B: begin
                     wr_data = cmd.word_b & VALUE_MASK;
                     step_in = STEP_MARKER;
                     cmd_pop = 1'b1;
                  end
                  default: begin
                     step_in = STEP_MARKER;
                  end
               endcase
            end
            CMD_CLEAR: begin
               cmd_pop = 1'b1;
            end
            CMD_READ: begin
               // wait until the response stage can take the result
               if (rd_slot_free) begin
                  rd_issue = 1'b1;
                  cmd_pop  = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      pend_in      = rd_issue;
      pend_hit_in  = 1'b0;
      pend_left_in = '0;
      pend_ovf_in  = ovf_ff;

      if (cmd_valid && cmd.kind == CMD_CLEAR) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end

      // drop the word and flag it when the log is full
      if (wr_en) begin
         tail_in  = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (wr_req) begin
         ovf_in = 1'b1;
      end

      if (rd_issue) begin
         ovf_in = 1'b0;
         if (count_ff != '0) begin
            head_in      = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            count_in     = count_dec;
            pend_hit_in  = 1'b1;
            pend_left_in = (count_dec > CNT_W'(LEFT_MAX)) ? LEFT_MAX
                                                          : LEFT_W'(count_dec);
         end
      end

      if (pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= STEP_MARKER;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fifo_mem_ff[tail_ff] <= wr_data;
      end
      mem_q_ff <= fifo_mem_ff[head_ff];
   end

   always_ff @(posedge clock) begin
      pend_hit_ff  <= pend_hit_in;
      pend_left_ff <= pend_left_in;
      pend_ovf_ff  <= pend_ovf_in;
      if (pend_ff) begin
         rsp_word_ff <= pend_hit_ff ? mem_q_ff : '0;
         rsp_hit_ff  <= pend_hit_ff;
         rsp_left_ff <= pend_left_ff;
         rsp_ovf_ff  <= pend_ovf_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.entry_word   = rsp_word_ff;
   assign rsp_ch.entry_valid  = rsp_hit_ff;
   assign rsp_ch.entries_left = rsp_left_ff;
   assign rsp_ch.overflowed   = rsp_ovf_ff;

   `DPLOG_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> (!pend_ff && !rsp_valid_ff && count_ff == '0),
      "back end not idle after reset")
   `DPLOG_ASSERT(a_count_bound, clock, reset,
      count_ff <= CNT_W'(FIFO_DEPTH),
      "log fill count beyond depth")
   `DPLOG_ASSERT(a_read_lands, clock, reset,
      pend_ff |=> rsp_valid_ff,
      "issued read did not reach the response stage")
   `DPLOG_ASSERT(a_empty_read, clock, reset,
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_word_ff == '0 && rsp_left_ff == '0),
      "empty read returned data or fill")
   `DPLOG_ASSERT(a_clear_empties, clock, reset,
      (cmd_valid && cmd_pop && cmd.kind == CMD_CLEAR) |=> (count_ff == '0 && !ovf_ff),
      "restart left words or overflow behind")

endmodule

### hdl/delta_position_log_encoder_unit.sv
// ----------------------------------------------------------------------------
// delta_position_log_encoder_unit
// Timed two-channel position logger with delta compression into a word FIFO.
// ----------------------------------------------------------------------------
// Requests (sample, read, restart) are taken one per clock while the
// four-entry command queue has room; the front end decides at once whether
// a sample is due and whether it is a relative entry or a resync. The back
// end owns the single-port-write FIFO memory: a relative entry writes one
// word, a restart none, a resync group one word per step (marker, stamp,
// value A, value B), and no read issues while the last one still passes
// the registered memory read ahead of the response register. A write to
// log_period_ms holds off requests while the due time is rebuilt. The FIFO
// contents are undefined after reset and need no clearing pass.
module delta_position_log_encoder_unit import dplog_pkg::*; #(
   parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   dplog_req_if.sink             req_ch,
   dplog_rsp_if.source           rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic    cmdq_full;
   logic    cmdq_push;
   cmd_type cmdq_cmd;
   logic    head_valid;
   cmd_type head_cmd;
   logic    head_pop;

   dplog_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmdq_full (cmdq_full),
      .cmdq_push (cmdq_push),
      .cmdq_cmd  (cmdq_cmd)
   );

   dplog_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmdq_push),
      .push_cmd   (cmdq_cmd),
      .full       (cmdq_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (head_pop)
   );

   dplog_back #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (head_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

### tb/sv/tb_delta_position_log_encoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delta_position_log_encoder_unit
// Self-checking bench for the position log encoder. A scripted sequence
// covers the corner cases (empty reads, disabled logging, resync marker
// bits, overflow, restart). Randomized phases under several register
// settings follow. Scripted reads are checked against the script, all others
// against an in-bench model of the log FIFO and delta/resync encoder. Both
// channels see random gaps, and the response side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_delta_position_log_encoder_unit import dplog_pkg::*;;

   localparam int LOG_DEPTH    = DEFAULT_FIFO_DEPTH;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 3000;
   localparam int LONG_HOLD    = 300;
   localparam int TX_SIDE      = 0;
   localparam int RX_SIDE      = 1;
   localparam logic [1:0] OP_UNDEF = 2'd3;
   localparam logic [30:0] NOW_MAX = 31'h7fff_ffff;

   typedef struct packed {
      logic [31:0] word;
      logic        valid;
      logic [7:0]  left;
      logic        ovf;
   } read_result_type;

   typedef enum {ROW_CSR, ROW_ITEM, ROW_CHECK} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_DATA_W-1:0]  data;
      logic [1:0]             op;
      logic [30:0]            now;
      logic [31:0]            a;
      logic [31:0]            b;
      int                     reps;
      read_result_type        want;
   } script_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dplog_req_if req_if ();
   dplog_rsp_if rsp_if ();

   delta_position_log_encoder_unit #(
      .FIFO_DEPTH (LOG_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // log model state
   logic                  log_on;
   logic [PERIOD_W-1:0]   period_ms;
   logic [SYNC_CNT_W-1:0] sync_entries;
   logic [31:0]           log_mem [LOG_DEPTH];
   int                    fill;
   int                    head;
   int                    tail;
   logic                  lost_words;
   int                    since_sync;
   longint                sync_ms;
   logic [31:0]           base_a;
   logic [31:0]           base_b;

   read_result_type pending_reads [$];
   script_row_type  script [$];
   int           mismatches = 0;
   int           reads_checked = 0;
   int           calm_left [2] = '{0, 0};
   int           stall_cycles = 0;
   longint       ms_clock = 0;
   logic [31:0]  va = 32'd0;
   logic [31:0]  vb = 32'd0;
   bit           filling = 1'b1;
   int           mode_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic void log_restart();
      fill       = 0;
      head       = 0;
      tail       = 0;
      lost_words = 1'b0;
      since_sync = int'(sync_entries);
      sync_ms    = -(longint'(sync_entries) + 1) * longint'(period_ms);
   endfunction

   function automatic void log_store(logic [31:0] w);
      if (fill >= LOG_DEPTH) begin
         lost_words = 1'b1;
         return;
      end
      log_mem[tail] = w;
      tail = (tail + 1) % LOG_DEPTH;
      fill++;
   endfunction

   function automatic void log_sample(logic [30:0] now, logic [31:0] a, logic [31:0] b);
      longint      due;
      logic [31:0] da;
      logic [31:0] db;
      if (!log_on)
         return;
      due = sync_ms + (longint'(since_sync) + 1) * longint'(period_ms);
      if (longint'(now) < due)
         return;
      since_sync++;
      if (since_sync <= int'(sync_entries)) begin
         da = a - base_a;
         db = b - base_b;
         log_store({db[15:0], da[15:0]});
      end else begin
         since_sync = 0;
         sync_ms    = longint'(now);
         // now_ms has no bit 31, so the marker's bit 0 stays low
         log_store(SYNC_MARKER | {29'd0, b[31], a[31], 1'b0});
         log_store({1'b0, now});
         base_a = a;
         log_store(a & VALUE_MASK);
         base_b = b;
         log_store(b & VALUE_MASK);
      end
   endfunction

   function automatic read_result_type log_read();
      read_result_type r;
      r.word  = 32'd0;
      r.valid = 1'b0;
      if (fill > 0) begin
         r.word  = log_mem[head];
         head    = (head + 1) % LOG_DEPTH;
         fill--;
         r.valid = 1'b1;
      end
      r.left     = (fill > 255) ? LEFT_MAX : 8'(fill);
      r.ovf      = lost_words;
      lost_words = 1'b0;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   function automatic int pick_gap(int side);
      int r;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left[side] = $urandom_range(30, 150);
         return 0;
      end
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(logic [1:0] op, logic [30:0] now, logic [31:0] a,
                            logic [31:0] b, bit typed, read_result_type want);
      int              gap;
      read_result_type got;
      gap = pick_gap(TX_SIDE);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.op      <= op;
      req_if.now_ms  <= now;
      req_if.value_a <= a;
      req_if.value_b <= b;
      do @(posedge clock); while (!req_if.ready);
      case (op)
         OP_SAMPLE:  log_sample(now, a, b);
         OP_RESTART: log_restart();
         OP_READ: begin
            got = log_read();
            pending_reads = {pending_reads, (typed ? want : got)};
         end
         default: ;
      endcase
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      req_if.valid <= 1'b0;
      while (pending_reads.size() != 0)
         @(posedge clock);
      // samples and restarts leave no response; let the queue drain
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LOG_ENABLE:   log_on       = val[0];
         CSR_LOG_PERIOD:   period_ms    = val[PERIOD_W-1:0];
         CSR_SYNC_ENTRIES: sync_entries = val[SYNC_CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_junk(logic [1:0] op);
      send_item(op, 31'($urandom), $urandom, $urandom, 1'b0, '0);
   endtask

   task automatic restart_at_new_base();
      ms_clock = $urandom_range(0, 1) ? $urandom_range(0, 5000)
                                      : $urandom_range(0, 32'h7800_0000);
      send_junk(OP_RESTART);
   endtask

   function automatic logic [31:0] walk_value(logic [31:0] v);
      int t;
      t = $urandom_range(0, 99);
      if (t < 4)
         return $urandom;
      if (t < 6)
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'h0000_0000;
         endcase
      return v + 32'($urandom_range(0, 4000)) - 32'd2000;
   endfunction

   task automatic run_phase(bit on, int period, int sync, int count);
      int     r;
      int     read_pct;
      longint adv_ms;
      csr_write(CSR_LOG_ENABLE, CSR_DATA_W'(on));
      csr_write(CSR_LOG_PERIOD, CSR_DATA_W'(period));
      csr_write(CSR_SYNC_ENTRIES, CSR_DATA_W'(sync));
      // sometimes keep the old sync state so new registers meet it
      if ($urandom_range(0, 1))
         restart_at_new_base();
      for (int n = 0; n < count; n++) begin
         if (mode_left == 0) begin
            filling   = ~filling;
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         read_pct = filling ? 12 : 55;
         r = $urandom_range(0, 99);
         if (r < 2) begin
            restart_at_new_base();
         end else if (r < 3) begin
            send_junk(OP_UNDEF);
         end else if (r < 3 + read_pct) begin
            send_junk(OP_READ);
         end else if (r < 3 + read_pct + 4) begin
            // stale timestamp with random content
            send_item(OP_SAMPLE, 31'($urandom_range(0, 32'(ms_clock))), $urandom,
                      $urandom, 1'b0, '0);
         end else begin
            if ($urandom_range(0, 9) == 0)
               adv_ms = $urandom_range(0, period / 2);
            else
               adv_ms = period + $urandom_range(0, period / 8 + 2);
            if (ms_clock + adv_ms > longint'(NOW_MAX)) begin
               restart_at_new_base();
            end else begin
               ms_clock = ms_clock + adv_ms;
               va = walk_value(va);
               vb = walk_value(vb);
               send_item(OP_SAMPLE, 31'(ms_clock), va, vb, 1'b0, '0);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- script
   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      script_row_type row;
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.data = val;
      script = {script, row};
   endfunction

   function automatic void add_item(logic [1:0] op, logic [30:0] now, logic [31:0] a,
                                    logic [31:0] b, int reps);
      script_row_type row;
      row.kind = ROW_ITEM;
      row.op   = op;
      row.now  = now;
      row.a    = a;
      row.b    = b;
      row.reps = reps;
      script = {script, row};
   endfunction

   function automatic void add_check(logic [31:0] w, logic v, logic [7:0] left, logic ovf);
      script_row_type row;
      row.kind = ROW_CHECK;
      row.want = '{w, v, left, ovf};
      script = {script, row};
   endfunction

   // ---------------------------------------------------------------- main
   initial begin
      req_if.valid   <= 1'b0;
      req_if.op      <= OP_SAMPLE;
      req_if.now_ms  <= '0;
      req_if.value_a <= '0;
      req_if.value_b <= '0;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_LOG_ENABLE;
      csr_wdata      <= '0;
      reset          <= 1'b1;
      log_on       = 1'b0;
      period_ms    = RESET_PERIOD_VAL;
      sync_entries = RESET_SYNC_VAL;
      base_a       = 32'd0;
      base_b       = 32'd0;
      log_restart();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_check(32'h0000_0000, 1'b0, 8'd0, 1'b0);
      add_item(OP_SAMPLE, 31'd1000, 32'd5, 32'd6, 1);           // logging off: ignored
      add_check(32'h0000_0000, 1'b0, 8'd0, 1'b0);
      add_csr(CSR_LOG_ENABLE, 16'd1);
      add_item(OP_SAMPLE, NOW_MAX, 32'h8000_0000, 32'h7fff_ffff, 1);
      add_check(32'h8000_0002, 1'b1, 8'd3, 1'b0);
      add_check(32'h7fff_ffff, 1'b1, 8'd2, 1'b0);
      add_check(32'h0000_0000, 1'b1, 8'd1, 1'b0);
      add_check(32'h7fff_ffff, 1'b1, 8'd0, 1'b0);
      add_item(OP_RESTART, 31'd0, 32'd0, 32'd0, 1);
      add_item(OP_SAMPLE, 31'd0, 32'hffff_ffff, 32'h8000_0000, 1);
      add_item(OP_SAMPLE, 31'd199, 32'd0, 32'd0, 1);            // one ms short of due
      add_item(OP_SAMPLE, 31'd200, 32'h0000_1233, 32'h7fff_ffff, 1);
      add_item(OP_UNDEF, NOW_MAX, 32'hffff_ffff, 32'hffff_ffff, 1);
      add_check(32'h8000_0006, 1'b1, 8'd4, 1'b0);
      add_check(32'h0000_0000, 1'b1, 8'd3, 1'b0);
      add_check(32'h7fff_ffff, 1'b1, 8'd2, 1'b0);
      add_check(32'h0000_0000, 1'b1, 8'd1, 1'b0);
      add_check(32'hffff_1234, 1'b1, 8'd0, 1'b0);
      // zero period and zero sync count: every sample resyncs, log overflows
      add_csr(CSR_LOG_PERIOD, 16'd0);
      add_csr(CSR_SYNC_ENTRIES, 16'd0);
      add_item(OP_RESTART, 31'd0, 32'd0, 32'd0, 1);
      add_item(OP_SAMPLE, 31'd5, 32'h1234_5678, 32'h9abc_def0, 40);
      add_check(32'h8000_0004, 1'b1, 8'd127, 1'b1);
      add_check(32'h0000_0005, 1'b1, 8'd126, 1'b0);
      add_item(OP_RESTART, 31'd0, 32'd0, 32'd0, 1);
      add_check(32'h0000_0000, 1'b0, 8'd0, 1'b0);

      foreach (script[i]) begin
         case (script[i].kind)
            ROW_CSR:  csr_write(script[i].idx, script[i].data);
            ROW_ITEM: begin
               repeat (script[i].reps)
                  send_item(script[i].op, script[i].now, script[i].a, script[i].b,
                            1'b0, '0);
            end
            default:  send_item(OP_READ, 31'($urandom), $urandom, $urandom, 1'b1,
                                script[i].want);
         endcase
      end

      run_phase(1'b1, 1, 1, 300);
      run_phase(1'b1, 65535, 255, 300);
      run_phase(1'b1, 0, 0, 250);
      run_phase(1'b0, 100, 10, 120);
      run_phase(1'b1, 200, 50, 300);
      run_phase(1'b1, $urandom_range(1, 1000), $urandom_range(1, 254), 300);
      run_phase(1'b1, 3, 7, 300);

      req_if.valid <= 1'b0;
      while (pending_reads.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------- response side
   initial begin
      int  gap;
      bit  held;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      repeat (4) @(posedge clock);
      forever begin
         // one long hold-off so the command queue backs up into the request side
         if (!held && reads_checked >= 100) begin
            held = 1'b1;
            gap  = LONG_HOLD;
         end else begin
            gap = pick_gap(RX_SIDE);
         end
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      read_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_reads.size() == 0) begin
            mismatches++;
            $display("%0t: response with no read outstanding, expected none actual %h",
                     $time, rsp_if.entry_word);
         end else begin
            want = pending_reads[0];
            pending_reads.delete(0);
            report_field("entry_word", want.word, rsp_if.entry_word);
            report_field("entry_valid", 32'(want.valid), 32'(rsp_if.entry_valid));
            report_field("entries_left", 32'(want.left), 32'(rsp_if.entries_left));
            report_field("overflowed", 32'(want.ovf), 32'(rsp_if.overflowed));
            reads_checked++;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) || csr_wr_en)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule

### files.f
+incdir+hdl
hdl/dplog_pkg.sv
hdl/dplog_req_if.sv
hdl/dplog_rsp_if.sv
hdl/dplog_front.sv
hdl/dplog_queue.sv
hdl/dplog_back.sv
hdl/delta_position_log_encoder_unit.sv
tb/sv/tb_delta_position_log_encoder_unit.sv
